/* hw/rtl/nearest_neighbor_tour_defines.svh */
// assertion macros shared by the nearest-neighbor tour checkers
// needs clk and rst_n in scope where the macros are used
`ifndef NEAREST_NEIGHBOR_TOUR_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NNT_CHK_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NNT_CHK_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/nnt_pkg.sv */
// shared types, constants and helpers for the nearest-neighbor tour block
// no dependencies
package nnt_pkg;

  localparam int DEF_MAX_CITIES = 16;

  localparam int KIND_W = 1;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int W_W    = 10;
  localparam int CITY_W = 4;
  localparam int COST_W = 14;
  localparam int CC_W   = 5;
  // wide enough to hold the largest supported city count
  localparam int CNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_START = 1'b1;

  localparam logic [W_W-1:0]    NO_PICK        = 10'd999;
  localparam logic [COST_W-1:0] COST_MAX       = 14'h3fff;
  localparam logic [CC_W-1:0]   CITY_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [W_W-1:0]    weight;
  } in_item_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic [COST_W-1:0] total_cost;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
    logic cfg_wr;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic out_free;
  } sts_t;

  function automatic logic [COST_W-1:0] add_sat(input logic [COST_W-1:0] a,
                                                input logic [W_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + (COST_W + 1)'(b);
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

/* hw/rtl/nnt_datapath.sv */
// datapath of the tour engine: cost matrix memory, row scan compare,
// tour state and the output register; uses nnt_pkg
module nnt_datapath #(
  parameter int MAX_CITIES = nnt_pkg::DEF_MAX_CITIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nnt_pkg::cmd_t               cmd,
  output nnt_pkg::sts_t               sts,
  input  nnt_pkg::in_item_t           in_data,
  input  logic [nnt_pkg::CC_W-1:0]    cfg_data,
  input  logic                        out_stall,
  output logic                        out_valid,
  output nnt_pkg::out_item_t          out_data
);

  localparam int CW    = $clog2(MAX_CITIES);
  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [MAX_CITIES-1:0] VIS_FIRST = MAX_CITIES'(1);

  logic [nnt_pkg::W_W-1:0]    mem [DEPTH];
  logic [nnt_pkg::W_W-1:0]    rdata_r;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic                       wr_ok;

  logic [nnt_pkg::CC_W-1:0]   city_count_r;
  logic [CW-1:0]              n_last;
  logic [CW-1:0]              idx_r;
  logic                       d_vld_r;
  logic [CW-1:0]              d_idx_r;
  logic [MAX_CITIES-1:0]      visited_r;
  logic [CW-1:0]              cur_r;
  logic [nnt_pkg::COST_W-1:0] run_r;
  logic [nnt_pkg::W_W-1:0]    best_cost_r;
  logic [CW-1:0]              best_city_r;
  logic                       found_r;
  logic [nnt_pkg::W_W-1:0]    ret_w_r;
  logic                       take;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  nnt_pkg::out_item_t         out_data_r;

  assign wr_ok = (nnt_pkg::CNT_W'(in_data.row) < nnt_pkg::CNT_W'(MAX_CITIES)) &&
                 (nnt_pkg::CNT_W'(in_data.col) < nnt_pkg::CNT_W'(MAX_CITIES));
  assign waddr = AW'(in_data.row) * AW'(MAX_CITIES) + AW'(in_data.col);
  assign raddr = AW'(cur_r) * AW'(MAX_CITIES) + AW'(idx_r);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem[waddr] <= in_data.weight;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  // zero acts as one city, anything past the matrix as the full matrix
  always_comb begin
    if (city_count_r == '0) begin
      n_last = '0;
    end else if (nnt_pkg::CNT_W'(city_count_r) > nnt_pkg::CNT_W'(MAX_CITIES)) begin
      n_last = CW'(MAX_CITIES - 1);
    end else begin
      n_last = CW'(city_count_r - 1'b1);
    end
  end

  // strict less-than over rising index keeps the lowest index on ties
  assign take = d_vld_r && (rdata_r != '0) && !visited_r[d_idx_r] &&
                (rdata_r < best_cost_r);

  assign out_valid_nxt = cmd.emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= nnt_pkg::CITY_COUNT_RST;
      idx_r        <= '0;
      d_vld_r      <= 1'b0;
      visited_r    <= '0;
      cur_r        <= '0;
      run_r        <= '0;
      best_cost_r  <= nnt_pkg::NO_PICK;
      best_city_r  <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      d_vld_r     <= cmd.scan;
      d_idx_r     <= idx_r;
      if (cmd.cfg_wr) begin
        city_count_r <= cfg_data;
      end
      if (cmd.scan) begin
        idx_r <= idx_r + 1'b1;
      end
      if (take) begin
        best_cost_r <= rdata_r;
        best_city_r <= d_idx_r;
        found_r     <= 1'b1;
      end
      // entry back to city 0 comes by on the first read of every row
      if (d_vld_r && (d_idx_r == '0)) begin
        ret_w_r <= rdata_r;
      end
      if (cmd.start) begin
        visited_r   <= VIS_FIRST;
        cur_r       <= '0;
        run_r       <= '0;
        idx_r       <= '0;
        best_cost_r <= nnt_pkg::NO_PICK;
        found_r     <= 1'b0;
      end
      if (cmd.emit) begin
        out_data_r.city       <= nnt_pkg::CITY_W'(cur_r);
        out_data_r.last       <= !found_r;
        out_data_r.total_cost <= found_r ? '0 : nnt_pkg::add_sat(run_r, ret_w_r);
        if (found_r) begin
          run_r                  <= nnt_pkg::add_sat(run_r, best_cost_r);
          cur_r                  <= best_city_r;
          visited_r[best_city_r] <= 1'b1;
        end
        idx_r       <= '0;
        best_cost_r <= nnt_pkg::NO_PICK;
        found_r     <= 1'b0;
      end
    end
  end

  assign sts.scan_end = (idx_r == n_last);
  assign sts.found    = found_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/nnt_ctrl.sv */
// controller of the tour engine: sequences load, row scans and result beats
// uses nnt_pkg command and status types
module nnt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [nnt_pkg::KIND_W-1:0]  in_kind,
  input  logic                        cfg_valid,
  input  nnt_pkg::sts_t               sts,
  output nnt_pkg::cmd_t               cmd,
  output logic                        in_stall,
  output logic                        cfg_ready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   idle;

  assign idle      = (state_r == ST_IDLE);
  assign in_stall  = !idle;
  assign cfg_ready = idle;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.cfg_wr = cfg_valid;
        if (in_valid) begin
          if (in_kind == nnt_pkg::KIND_START) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read of the row still in the compare stage
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.found ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/nearest_neighbor_tour.sv */
// Greedy nearest-neighbor tour over a loaded cost matrix. Load beats inside
// the matrix write one entry each; load beats are taken one per cycle while
// no tour runs. A start beat runs a tour from city 0 and gives one result
// beat per visited city, the last one flagged with the total cost including
// the edge back to city 0. For each visited city the engine makes n reads of
// that city's row through the single read port of the matrix memory, n being
// the city count in use, finishes the last compare in a drain state, and
// then hands the beat to the output register, waiting while out_stall holds.
// During a whole tour in_stall is high and the configuration port is not
// ready. The matrix has no reset value.
// Depends on nnt_pkg, nnt_ctrl and nnt_datapath.
module nearest_neighbor_tour #(
  parameter int MAX_CITIES = nnt_pkg::DEF_MAX_CITIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  nnt_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output nnt_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [nnt_pkg::CC_W-1:0]  cfg_data
);

  nnt_pkg::cmd_t cmd;
  nnt_pkg::sts_t sts;

  nnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  nnt_datapath #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/nnt_checker.sv */
// port-level checks for the tour engine, bound to the top level
// uses nnt_pkg types and the macros in nearest_neighbor_tour_defines.svh
`include "nearest_neighbor_tour_defines.svh"

module nnt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input nnt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input nnt_pkg::out_item_t out_data
);

  // a start beat always occupies the engine for at least the next cycle
  `NNT_CHK_NEXT(a_start_busy, in_valid && !in_stall && (in_data.kind == nnt_pkg::KIND_START), in_stall, "start beat did not make the engine busy")

  // load beats never block the following beat
  `NNT_CHK_NEXT(a_load_stream, in_valid && !in_stall && (in_data.kind == nnt_pkg::KIND_LOAD), !in_stall, "load beat stalled the next beat")

  // only the final city carries a total
  `NNT_CHK_NOW(a_total_on_last, out_valid && !out_data.last, out_data.total_cost == '0, "total cost on a non-final beat")

  `NNT_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind nearest_neighbor_tour nnt_checker u_nnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
